### rtl/core/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types and constants of the integer stack machine: operation and
// status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEF_STACK_DEPTH = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_PRINT_ALL = 3'd2,
    OP_PRINT_TOP = 3'd3,
    OP_SWAP      = 3'd4,
    OP_ADD       = 3'd5,
    OP_SUB       = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One result item as it leaves the controller.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     value_valid;
    status_e                  status;
    logic                     last;
  } result_t;

endpackage

### rtl/core/ism_ram.sv
// ----------------------------------------------------------------------------
// ism_ram
// Entry store below the top of the stack: one write port and one read port,
// with registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ism_ram #(
  parameter int unsigned DEPTH  = ism_pkg::DEF_STACK_DEPTH - 1,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [ADDR_W-1:0]                waddr_i,
  input  logic signed [ism_pkg::DATA_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [ADDR_W-1:0]                raddr_i,
  output logic signed [ism_pkg::DATA_W-1:0] rdata_o
);

  logic signed [ism_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic signed [ism_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ism_ctrl.sv
// ----------------------------------------------------------------------------
// ism_ctrl
// Sequencer of the stack machine: keeps the top entry and the depth in
// registers, reads the second entry from the store, carries out one operation
// and streams the store for print_all.
// ----------------------------------------------------------------------------
module ism_ctrl #(
  parameter int unsigned STACK_DEPTH = ism_pkg::DEF_STACK_DEPTH,
  parameter int unsigned ADDR_W      = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ism_pkg::OP_W-1:0]          operation_i,
  input  logic signed [ism_pkg::DATA_W-1:0] push_value_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output ism_pkg::result_t                  res_o,
  output logic                              we_o,
  output logic [ADDR_W-1:0]                 waddr_o,
  output logic signed [ism_pkg::DATA_W-1:0] wdata_o,
  output logic                              re_o,
  output logic [ADDR_W-1:0]                 raddr_o,
  input  logic signed [ism_pkg::DATA_W-1:0] rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STREAM
  } state_e;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

  state_e                            state_q, state_d;
  logic [ism_pkg::OP_W-1:0]          op_q, op_d;
  logic signed [ism_pkg::DATA_W-1:0] val_q, val_d;
  logic signed [ism_pkg::DATA_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [ADDR_W-1:0]                 ptr_q, ptr_d;
  logic [CNT_W-1:0]                  cnt_m1, cnt_m2;

  assign cnt_m1     = cnt_q - ONE_CNT;
  assign cnt_m2     = cnt_q - TWO_CNT;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    we_o        = 1'b0;
    waddr_o     = cnt_m1[ADDR_W-1:0];
    wdata_o     = top_q;
    re_o        = 1'b0;
    raddr_o     = cnt_m2[ADDR_W-1:0];
    res_valid_o = 1'b0;
    res_o       = '{read_value: '0, value_valid: 1'b0,
                    status: ism_pkg::ST_OK, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          val_d   = push_value_i;
          state_d = S_EXEC;
          // Fetch the second entry now; it is ready in the next cycle.
          re_o    = (cnt_q >= TWO_CNT);
        end
      end
      S_EXEC: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          case (ism_pkg::op_e'(op_q))
            ism_pkg::OP_PUSH: begin
              if (cnt_q == FULL_CNT) begin
                res_o.status = ism_pkg::ST_FULL;
              end else begin
                we_o  = (cnt_q != '0);
                top_d = val_q;
                cnt_d = cnt_q + ONE_CNT;
              end
            end
            ism_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                res_o.status = ism_pkg::ST_SHORT;
              end else begin
                top_d = rdata_i;
                cnt_d = cnt_m1;
              end
            end
            ism_pkg::OP_PRINT_ALL: begin
              if (cnt_q != '0) begin
                res_o.read_value  = top_q;
                res_o.value_valid = 1'b1;
                res_o.last        = (cnt_q == ONE_CNT);
                if (cnt_q >= TWO_CNT) begin
                  state_d = S_STREAM;
                  ptr_d   = cnt_m2[ADDR_W-1:0];
                end
              end
            end
            ism_pkg::OP_PRINT_TOP: begin
              if (cnt_q == '0) begin
                res_o.status = ism_pkg::ST_SHORT;
              end else begin
                res_o.read_value  = top_q;
                res_o.value_valid = 1'b1;
              end
            end
            ism_pkg::OP_SWAP, ism_pkg::OP_ADD, ism_pkg::OP_SUB: begin
              if (cnt_q < TWO_CNT) begin
                res_o.status = ism_pkg::ST_SHORT;
              end else if (ism_pkg::op_e'(op_q) == ism_pkg::OP_SWAP) begin
                we_o    = 1'b1;
                waddr_o = cnt_m2[ADDR_W-1:0];
                top_d   = rdata_i;
              end else begin
                top_d = (ism_pkg::op_e'(op_q) == ism_pkg::OP_ADD) ?
                        rdata_i + top_q : rdata_i - top_q;
                cnt_d = cnt_m1;
              end
            end
            default: begin
              // The unused code leaves the stack as it is.
            end
          endcase
        end
      end
      S_STREAM: begin
        if (res_ready_i) begin
          res_valid_o       = 1'b1;
          res_o.read_value  = rdata_i;
          res_o.value_valid = 1'b1;
          res_o.last        = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            re_o    = 1'b1;
            raddr_o = ptr_q - ADDR_W'(1);
            ptr_d   = ptr_q - ADDR_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    top_q <= top_d;
    ptr_q <= ptr_d;
  end

endmodule

### rtl/core/integer_stack_machine.sv
// ----------------------------------------------------------------------------
// integer_stack_machine
// Bounded stack of 32-bit signed integers running one operation per input
// transfer: push, pop, print_all, print_top, swap, add and sub.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                Payload
//   -------   ---------   ----------------------   ------------------------------
//   in        input       in_valid_i / in_ready_o  operation_i, push_value_i
//   out       output      out_valid_o/out_ready_i  read_value_o, value_valid_o,
//                                                  status_o, last_o
//
// An input transfer is first accepted, which issues the read of the second
// entry from the store, and then applied once the read data is back. print_all
// then gives one further result per cycle, unless the output stalls, for each
// stored entry below the top, paced by the single read port of the store.
// Reset clears the controller state, the depth count and the output valid
// flag; the store needs no clearing pass, as no entry at or above the depth is read.
// A stalled output holds the controller in place; a finished result sits in
// the output register, which drains independently of the controller.
//
// The top entry lives in a register inside the controller; the store holds
// the entries beneath it, so it needs one entry fewer than the stack depth.
// Writes happen only in the apply cycle and reads only in the accept or
// streaming cycles, so a read never meets a write to the same entry.
module integer_stack_machine #(
  parameter int unsigned STACK_DEPTH = ism_pkg::DEF_STACK_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ism_pkg::OP_W-1:0]          operation_i,
  input  logic signed [ism_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ism_pkg::DATA_W-1:0] read_value_o,
  output logic                              value_valid_o,
  output logic [ism_pkg::STATUS_W-1:0]      status_o,
  output logic                              last_o
);

  // The store holds every entry but the top one.
  localparam int unsigned RAM_DEPTH = STACK_DEPTH - 1;
  localparam int unsigned ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);

  logic                              res_valid;
  logic                              res_ready;
  ism_pkg::result_t                  res;
  logic                              we;
  logic [ADDR_W-1:0]                 waddr;
  logic signed [ism_pkg::DATA_W-1:0] wdata;
  logic                              re;
  logic [ADDR_W-1:0]                 raddr;
  logic signed [ism_pkg::DATA_W-1:0] rdata;

  logic                              out_valid_q, out_valid_d;
  ism_pkg::result_t                  out_res_q;

  ism_ram #(
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ism_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .re_o         (re),
    .raddr_o      (raddr),
    .rdata_i      (rdata)
  );

  // The output register can take a new result when it is empty or when its
  // current result is being transferred in this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_res_q.read_value;
  assign value_valid_o = out_res_q.value_valid;
  assign status_o      = out_res_q.status;
  assign last_o        = out_res_q.last;

  // The controller only hands over a result when the output register has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_ready)
    else $error("result produced while the output register was full");

  // One operation at a time: the cycle after an input transfer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while the previous operation was applied");

  // A result carrying no entry is always the final one and reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !value_valid_o) |-> (last_o && (read_value_o == '0)))
    else $error("result without an entry is not final or not zero");

  // A result carrying an entry always reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_valid_o) |-> (status_o == ism_pkg::ST_OK))
    else $error("result with an entry reports an error status");

endmodule
